@@ sv/timer_based_uart_transceiver_core_defines.svh @@
// ----------------------------------------------------------------------------
// Timer-based UART transceiver assertion macros
// Shared concurrent assertion wrappers clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef TIMER_BASED_UART_TRANSCEIVER_CORE_DEFINES_SVH
`define TIMER_BASED_UART_TRANSCEIVER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TBUT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TBUT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/tbut_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer-based UART transceiver package
// Widths, frame constants and the result types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbut_pkg;

   localparam int TIMER_WIDTH   = 16;
   localparam int CSR_WIDTH     = 16;
   localparam int PERIOD_WIDTH  = (TIMER_WIDTH < CSR_WIDTH) ? TIMER_WIDTH : CSR_WIDTH;
   localparam int RX_TICK_WIDTH = PERIOD_WIDTH + 1;
   localparam int TX_TICK_WIDTH = PERIOD_WIDTH;

   localparam logic [CSR_WIDTH-1:0] BIT_PERIOD_RESET = CSR_WIDTH'(138);
   localparam logic [3:0]           RX_FRAME_BITS    = 4'd9;
   localparam logic [3:0]           TX_FRAME_BITS    = 4'd10;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_result_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_result_type;

endpackage

@@ sv/tbut_if.sv @@
// ----------------------------------------------------------------------------
// Timer-based UART transceiver channel interfaces
// Valid/ready channels for the tick beat and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbut_req_if;
   logic       valid;
   logic       ready;
   logic       rx_line;
   logic       send_request;
   logic [7:0] send_byte;

   modport source (output valid, output rx_line, output send_request, output send_byte,
                   input ready);
   modport sink   (input valid, input rx_line, input send_request, input send_byte,
                   output ready);
endinterface

interface tbut_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_line;
   logic       tx_busy;
   logic       rx_valid;
   logic [7:0] rx_byte;

   modport source (output valid, output tx_line, output tx_busy, output rx_valid,
                   output rx_byte, input ready);
   modport sink   (input valid, input tx_line, input tx_busy, input rx_valid,
                   input rx_byte, output ready);
endinterface

@@ sv/timer_based_uart_transceiver_core.sv @@
// ----------------------------------------------------------------------------
// Timer-based UART transceiver core
// 8N1 receiver and transmitter advanced by one clock tick per input beat.
//
//   Channel  Dir  Carries
//   req      in   rx_line, send_request, send_byte (one tick per beat)
//   rsp      out  tx_line, tx_busy, rx_valid, rx_byte (one result per beat)
//   csr      in   bit_period write (write enable and data)
//
// One beat is accepted per cycle; its result sits in the output register the
// next cycle. The state update of receiver and transmitter, done once per beat, sets
// this rate. The input is taken while the output register is empty or being
// drained, so a stalled result holds the input back. Synchronous reset
// returns both sides to idle and the bit period to 138.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_based_uart_transceiver_core_defines.svh"

module timer_based_uart_transceiver_core (
   input  logic                           clock,
   input  logic                           reset,
   tbut_req_if.sink                       req,
   tbut_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [tbut_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import tbut_pkg::*;

   logic [CSR_WIDTH-1:0]    bit_period_ff;
   logic [PERIOD_WIDTH-1:0] period;
   logic                    accept;
   logic                    rsp_valid_ff, rsp_valid_in;
   rx_result_type           rx_result;
   tx_result_type           tx_result;
   rx_result_type           rx_out_ff;
   tx_result_type           tx_out_ff;

   assign period    = bit_period_ff[PERIOD_WIDTH-1:0];
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RESET;
      end else if (csr_write_enable) begin
         bit_period_ff <= csr_write_data;
      end
   end

   tbut_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .rx_line (req.rx_line),
      .period  (period),
      .result  (rx_result)
   );

   tbut_tx u_tx (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .send_request (req.send_request),
      .send_byte    (req.send_byte),
      .period       (period),
      .result       (tx_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rx_out_ff <= rx_result;
         tx_out_ff <= tx_result;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.tx_line  = tx_out_ff.line;
   assign rsp.tx_busy  = tx_out_ff.busy;
   assign rsp.rx_valid = rx_out_ff.valid;
   assign rsp.rx_byte  = rx_out_ff.data;

   `TBUT_ASSERT(a_rx_byte_zero_when_idle, rsp.valid && !rsp.rx_valid |-> rsp.rx_byte == 8'd0, "rx_byte nonzero without rx_valid")
   `TBUT_ASSERT(a_tx_mark_when_idle, rsp.valid && !rsp.tx_busy |-> rsp.tx_line, "tx_line low while transmitter idle")
   `TBUT_ASSERT_ALWAYS(a_reset_clears_output, reset |=> !rsp.valid, "result beat valid after reset")

endmodule

@@ sv/tbut_rx.sv @@
// ----------------------------------------------------------------------------
// Timer-based UART receiver
// Start edge detect, mid-bit sampling and nine-sample shift per tick beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbut_rx (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            rx_line,
   input  logic [tbut_pkg::PERIOD_WIDTH-1:0] period,
   output tbut_pkg::rx_result_type         result
);
   import tbut_pkg::*;

   logic                     prev_ff, prev_in;
   logic                     in_frame_ff, in_frame_in;
   logic [RX_TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [8:0]               shift_ff, shift_in;
   logic [3:0]               bits_ff, bits_in;
   logic [8:0]               shifted;
   logic [3:0]               bits_dec;

   assign shifted  = {rx_line, shift_ff[8:1]};
   assign bits_dec = bits_ff - 4'd1;

   always_comb begin
      prev_in      = rx_line;
      in_frame_in  = in_frame_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      bits_in      = bits_ff;
      result.valid = 1'b0;
      result.data  = 8'd0;
      if (in_frame_ff) begin
         if (tick_ff <= RX_TICK_WIDTH'(1)) begin
            tick_in  = RX_TICK_WIDTH'(period);
            shift_in = shifted;
            bits_in  = bits_dec;
            if (bits_dec == 4'd0) begin
               result.valid = 1'b1;
               result.data  = shifted[7:0];
               in_frame_in  = 1'b0;
               bits_in      = RX_FRAME_BITS;
               shift_in     = 9'd0;
            end
         end else begin
            tick_in = tick_ff - RX_TICK_WIDTH'(1);
         end
      end else if (prev_ff && !rx_line) begin
         in_frame_in = 1'b1;
         tick_in     = RX_TICK_WIDTH'(period) + RX_TICK_WIDTH'(period >> 1);
         bits_in     = RX_FRAME_BITS;
         shift_in    = 9'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b1;
         in_frame_ff <= 1'b0;
         tick_ff     <= '0;
         shift_ff    <= '0;
         bits_ff     <= RX_FRAME_BITS;
      end else if (step) begin
         prev_ff     <= prev_in;
         in_frame_ff <= in_frame_in;
         tick_ff     <= tick_in;
         shift_ff    <= shift_in;
         bits_ff     <= bits_in;
      end
   end

endmodule

@@ sv/tbut_tx.sv @@
// ----------------------------------------------------------------------------
// Timer-based UART transmitter
// Frames a byte as start, eight data bits and stop, one level per bit period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbut_tx (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              send_request,
   input  logic [7:0]                        send_byte,
   input  logic [tbut_pkg::PERIOD_WIDTH-1:0] period,
   output tbut_pkg::tx_result_type           result
);
   import tbut_pkg::*;

   logic                     active_ff, active_in;
   logic                     level_ff, level_in;
   logic [TX_TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [9:0]               shift_ff, shift_in;
   logic [3:0]               bits_ff, bits_in;

   always_comb begin
      active_in = active_ff;
      level_in  = level_ff;
      tick_in   = tick_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      if (active_ff) begin
         if (tick_ff <= TX_TICK_WIDTH'(1)) begin
            tick_in = TX_TICK_WIDTH'(period);
            if (bits_ff == 4'd0) begin
               active_in = 1'b0;
               bits_in   = TX_FRAME_BITS;
            end else begin
               level_in = shift_ff[0];
               shift_in = {1'b0, shift_ff[9:1]};
               bits_in  = bits_ff - 4'd1;
            end
         end else begin
            tick_in = tick_ff - TX_TICK_WIDTH'(1);
         end
      end else if (send_request) begin
         shift_in  = {1'b1, send_byte, 1'b0};
         bits_in   = TX_FRAME_BITS;
         tick_in   = TX_TICK_WIDTH'(period);
         active_in = 1'b1;
      end
      result.line = level_in;
      result.busy = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         level_ff  <= 1'b1;
         tick_ff   <= '0;
         shift_ff  <= '0;
         bits_ff   <= TX_FRAME_BITS;
      end else if (step) begin
         active_ff <= active_in;
         level_ff  <= level_in;
         tick_ff   <= tick_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
      end
   end

endmodule
